FILE: hdl/mgm_pkg.sv
`timescale 1ns / 1ps

package mgm_pkg;

    // Cipher geometry.
    localparam int unsigned ROUNDS    = 32;
    localparam int unsigned KEY_WORDS = 8;
    localparam int unsigned KEY_IDX_W = $clog2(KEY_WORDS);
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ROT_AMT   = 11;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [KEY_WORDS-1:0] key_array_t;
    typedef logic [KEY_IDX_W-1:0] key_idx_t;

    // Fixed S-boxes; row n serves nibble n counted from the least significant end.
    localparam logic [3:0] SBOX [8][16] = '{
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
    };

    // Round key schedule: K1..K8 three times, then K8..K1.
    function automatic key_idx_t key_index(input int unsigned rnd);
        key_idx_t lowbits;
        lowbits = key_idx_t'(rnd % KEY_WORDS);
        if (rnd < (ROUNDS - KEY_WORDS)) begin
            return lowbits;
        end
        return key_idx_t'(KEY_WORDS - 1) - lowbits;
    endfunction

    // Round function: modular add, nibble substitution, rotate left by 11.
    function automatic word_t round_fn(input word_t key, input word_t data);
        word_t sum;
        word_t sub;
        sum = data + key;
        for (int n = 0; n < 8; n++) begin
            sub[n*4 +: 4] = SBOX[n][sum[n*4 +: 4]];
        end
        return {sub[WORD_W-ROT_AMT-1:0], sub[WORD_W-1:WORD_W-ROT_AMT]};
    endfunction

endpackage

FILE: hdl/magma_block_encrypt_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                                   Handshake
// input     in         s_plain_high, s_plain_low               s_valid / s_ready
// result    out        m_cipher_high, m_cipher_low             m_valid / m_ready
// key cfg   in         cfg_index, cfg_data                     cfg_we (no wait)
//
// One round per register stage, 32 stages; one block may enter every cycle
// unless all stages are full and the result stage waits on m_ready.
// Each stage refills as soon as its beat moves on, so empty stages keep taking
// beats while the result stage waits on m_ready.
// Reset (aresetn, synchronous) empties all stages and clears the key to zero.

module magma_block_encrypt_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  mgm_pkg::key_idx_t cfg_index,
    input  mgm_pkg::word_t    cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  mgm_pkg::word_t    s_plain_high,
    input  mgm_pkg::word_t    s_plain_low,
    output logic              m_valid,
    input  logic              m_ready,
    output mgm_pkg::word_t    m_cipher_high,
    output mgm_pkg::word_t    m_cipher_low
);
    import mgm_pkg::*;

    key_array_t key_words;
    logic       stg_valid [ROUNDS+1];
    logic       stg_ready [ROUNDS+1];
    word_t      stg_hi    [ROUNDS+1];
    word_t      stg_lo    [ROUNDS+1];

    // Key word registers.
    mgm_key_regs u_keys (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_words (key_words)
    );

    // Pipeline entry.
    assign stg_valid[0] = s_valid;
    assign s_ready      = stg_ready[0];
    assign stg_hi[0]    = s_plain_high;
    assign stg_lo[0]    = s_plain_low;

    // Round stages, each with its fixed key word.
    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        mgm_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[r]),
            .in_ready  (stg_ready[r]),
            .in_hi     (stg_hi[r]),
            .in_lo     (stg_lo[r]),
            .round_key (key_words[key_index(r)]),
            .out_valid (stg_valid[r+1]),
            .out_ready (stg_ready[r+1]),
            .out_hi    (stg_hi[r+1]),
            .out_lo    (stg_lo[r+1])
        );
    end

    // The last round has no half swap, so undo the stage's swap at the output.
    assign stg_ready[ROUNDS] = m_ready;
    assign m_valid           = stg_valid[ROUNDS];
    assign m_cipher_high     = stg_lo[ROUNDS];
    assign m_cipher_low      = stg_hi[ROUNDS];

endmodule

FILE: hdl/mgm_key_regs.sv
`timescale 1ns / 1ps

module mgm_key_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  mgm_pkg::key_idx_t cfg_index,
    input  mgm_pkg::word_t    cfg_data,
    output mgm_pkg::key_array_t key_words
);
    import mgm_pkg::*;

    key_array_t key_reg;
    key_array_t key_next;

    // Write the addressed key word; the others hold.
    always_comb begin
        key_next = key_reg;
        if (cfg_we) begin
            key_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    assign key_words = key_reg;

endmodule

FILE: hdl/mgm_round.sv
`timescale 1ns / 1ps

module mgm_round (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  mgm_pkg::word_t in_hi,
    input  mgm_pkg::word_t in_lo,
    input  mgm_pkg::word_t round_key,
    output logic           out_valid,
    input  logic           out_ready,
    output mgm_pkg::word_t out_hi,
    output mgm_pkg::word_t out_lo
);
    import mgm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    word_t hi_reg;
    word_t hi_next;
    word_t lo_reg;
    word_t lo_next;
    logic  load;

    // The stage takes a new beat when it is empty or its content moves on.
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_ready;

    // One Feistel round with the usual half swap.
    always_comb begin
        valid_next = valid_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (load) begin
            valid_next = in_valid;
            hi_next    = in_lo;
            lo_next    = round_fn(round_key, in_lo) ^ in_hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign out_valid = valid_reg;
    assign out_hi    = hi_reg;
    assign out_lo    = lo_reg;

endmodule
